// ===== design/ilt_pkg.sv =====
// shared types and constants for the ini line tokenizer
`default_nettype none

package ilt_pkg;

    // one raw item from the file stream
    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_file;
    } ilt_in_t;

    // one result item
    typedef struct packed {
        logic [2:0]  byte_role;
        logic        line_done;
        logic [1:0]  line_kind;
        logic        has_value;
        logic        has_comment;
        logic [15:0] name_length;
        logic [15:0] value_length;
        logic [63:0] value_number;
    } ilt_out_t;

    // classified byte handed from front to back
    typedef struct packed {
        logic       brk;
        logic       ws;
        logic       hash;
        logic       eq;
        logic       is_x;
        logic       is_dec;
        logic       is_hex_letter;
        logic [3:0] nibble;
        logic       eof;
    } ilt_class_t;

    // per-line flags
    typedef struct packed {
        logic err;
        logic comment;
        logic value;
        logic name;
    } ilt_flags_t;

    // parser phase, one-hot
    typedef enum logic [7:0] {
        PH_LEAD       = 8'b0000_0001,
        PH_NAME       = 8'b0000_0010,
        PH_AFTER_NAME = 8'b0000_0100,
        PH_AFTER_EQ   = 8'b0000_1000,
        PH_VALUE      = 8'b0001_0000,
        PH_TRAIL      = 8'b0010_0000,
        PH_COMMENT    = 8'b0100_0000,
        PH_ERROR      = 8'b1000_0000
    } ilt_phase_t;

    localparam logic [2:0] ROLE_SKIP    = 3'd0;
    localparam logic [2:0] ROLE_NAME    = 3'd1;
    localparam logic [2:0] ROLE_EQUALS  = 3'd2;
    localparam logic [2:0] ROLE_VALUE   = 3'd3;
    localparam logic [2:0] ROLE_COMMENT = 3'd4;
    localparam logic [2:0] ROLE_BREAK   = 3'd5;

    localparam logic [1:0] KIND_BLANK   = 2'd0;
    localparam logic [1:0] KIND_ENTRY   = 2'd1;
    localparam logic [1:0] KIND_COMMENT = 2'd2;
    localparam logic [1:0] KIND_ERROR   = 2'd3;

    localparam logic [7:0] CHR_CR    = 8'd13;
    localparam logic [7:0] CHR_LF    = 8'd10;
    localparam logic [7:0] CHR_SPACE = 8'd32;
    localparam logic [7:0] CHR_TAB   = 8'd9;
    localparam logic [7:0] CHR_HASH  = 8'h23;
    localparam logic [7:0] CHR_EQ    = 8'h3D;
    localparam logic [7:0] CHR_LOW_X = 8'h78;
    localparam logic [7:0] CHR_UP_X  = 8'h58;

    localparam int QUEUE_DEPTH = 2;

endpackage

`default_nettype wire

// ===== design/ilt_front.sv =====
// front end: accepts bytes and classifies them for the parser
`default_nettype none

module ilt_front
    import ilt_pkg::*;
(
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire ilt_in_t    in_data,
    input  wire logic       q_full,
    output logic            q_push,
    output ilt_class_t      q_data
);

    logic [7:0] b;

    assign b        = in_data.in_byte;
    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        q_data.brk           = (b == CHR_CR) || (b == CHR_LF);
        q_data.ws            = (b == CHR_SPACE) || (b == CHR_TAB);
        q_data.hash          = (b == CHR_HASH);
        q_data.eq            = (b == CHR_EQ);
        q_data.is_x          = (b == CHR_LOW_X) || (b == CHR_UP_X);
        q_data.is_dec        = b inside {[8'h30:8'h39]};
        q_data.is_hex_letter = b inside {[8'h41:8'h46], [8'h61:8'h66]};
        q_data.eof           = in_data.end_of_file;
        // letters a-f and A-F have low nibble 1..6
        if (q_data.is_dec)
        begin
            q_data.nibble = b[3:0];
        end
        else
        begin
            q_data.nibble = 4'(b[3:0] + 4'd9);
        end
    end

endmodule

`default_nettype wire

// ===== design/ilt_queue.sv =====
// small queue between front and back
`default_nettype none

module ilt_queue
    import ilt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire ilt_class_t  push_data,
    output logic             full,
    input  wire logic        pop,
    output logic             not_empty,
    output ilt_class_t       pop_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    ilt_class_t        slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== design/ilt_back.sv =====
// back end: line parser, number accumulator and output register
`default_nettype none

module ilt_back
    import ilt_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        q_not_empty,
    input  wire ilt_class_t  q_data,
    output logic             q_pop,
    output logic             out_valid,
    input  wire logic        out_ready,
    output ilt_out_t         out_data
);

    localparam int EXT_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

    ilt_phase_t             phase_reg, phase_next;
    logic [63:0]            acc_reg, acc_next;
    logic                   hex_reg, hex_next;
    logic                   stopped_reg, stopped_next;
    logic [1:0]             idx_reg, idx_next;
    logic [COUNT_WIDTH-1:0] name_cnt_reg, name_cnt_next;
    logic [COUNT_WIDTH-1:0] value_cnt_reg, value_cnt_next;
    ilt_flags_t             flags_reg, flags_next;
    logic                   out_valid_reg;
    ilt_out_t               out_reg, out_next;

    logic       value_byte;
    logic       close_line;
    logic [EXT_W-1:0] name_ext, value_ext;

    assign q_pop     = q_not_empty && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    function automatic logic [COUNT_WIDTH-1:0] count_inc(input logic [COUNT_WIDTH-1:0] c);
        count_inc = (c == '1) ? c : c + 1'b1;
    endfunction

    always_comb
    begin
        phase_next     = phase_reg;
        acc_next       = acc_reg;
        hex_next       = hex_reg;
        stopped_next   = stopped_reg;
        idx_next       = idx_reg;
        name_cnt_next  = name_cnt_reg;
        value_cnt_next = value_cnt_reg;
        flags_next     = flags_reg;
        value_byte     = 1'b0;
        out_next       = '0;
        out_next.byte_role = ROLE_SKIP;

        if (q_data.brk)
        begin
            out_next.byte_role = ROLE_BREAK;
        end
        else
        begin
            case (phase_reg)
                PH_LEAD:
                begin
                    if (q_data.ws)
                    begin
                        out_next.byte_role = ROLE_SKIP;
                    end
                    else if (q_data.hash)
                    begin
                        flags_next.comment = 1'b1;
                        phase_next         = PH_COMMENT;
                        out_next.byte_role = ROLE_COMMENT;
                    end
                    else
                    begin
                        flags_next.name = 1'b1;
                        if (q_data.eq)
                        begin
                            flags_next.value   = 1'b1;
                            phase_next         = PH_AFTER_EQ;
                            out_next.byte_role = ROLE_EQUALS;
                        end
                        else
                        begin
                            name_cnt_next      = count_inc(name_cnt_reg);
                            phase_next         = PH_NAME;
                            out_next.byte_role = ROLE_NAME;
                        end
                    end
                end
                PH_NAME:
                begin
                    if (q_data.ws)
                    begin
                        phase_next = PH_AFTER_NAME;
                    end
                    else if (q_data.hash)
                    begin
                        flags_next.comment = 1'b1;
                        phase_next         = PH_COMMENT;
                        out_next.byte_role = ROLE_COMMENT;
                    end
                    else if (q_data.eq)
                    begin
                        flags_next.value   = 1'b1;
                        phase_next         = PH_AFTER_EQ;
                        out_next.byte_role = ROLE_EQUALS;
                    end
                    else
                    begin
                        name_cnt_next      = count_inc(name_cnt_reg);
                        out_next.byte_role = ROLE_NAME;
                    end
                end
                PH_AFTER_NAME:
                begin
                    if (q_data.ws)
                    begin
                        out_next.byte_role = ROLE_SKIP;
                    end
                    else if (q_data.hash)
                    begin
                        flags_next.comment = 1'b1;
                        phase_next         = PH_COMMENT;
                        out_next.byte_role = ROLE_COMMENT;
                    end
                    else if (q_data.eq)
                    begin
                        flags_next.value   = 1'b1;
                        phase_next         = PH_AFTER_EQ;
                        out_next.byte_role = ROLE_EQUALS;
                    end
                    else
                    begin
                        flags_next.err = 1'b1;
                        phase_next     = PH_ERROR;
                    end
                end
                PH_AFTER_EQ:
                begin
                    if (q_data.ws)
                    begin
                        out_next.byte_role = ROLE_SKIP;
                    end
                    else if (q_data.hash)
                    begin
                        flags_next.comment = 1'b1;
                        phase_next         = PH_COMMENT;
                        out_next.byte_role = ROLE_COMMENT;
                    end
                    else
                    begin
                        value_byte = 1'b1;
                    end
                end
                PH_VALUE:
                begin
                    if (q_data.ws)
                    begin
                        phase_next = PH_TRAIL;
                    end
                    else if (q_data.hash)
                    begin
                        flags_next.comment = 1'b1;
                        phase_next         = PH_COMMENT;
                        out_next.byte_role = ROLE_COMMENT;
                    end
                    else
                    begin
                        value_byte = 1'b1;
                    end
                end
                PH_TRAIL:
                begin
                    if (q_data.ws)
                    begin
                        out_next.byte_role = ROLE_SKIP;
                    end
                    else if (q_data.hash)
                    begin
                        flags_next.comment = 1'b1;
                        phase_next         = PH_COMMENT;
                        out_next.byte_role = ROLE_COMMENT;
                    end
                    else
                    begin
                        flags_next.err = 1'b1;
                        phase_next     = PH_ERROR;
                    end
                end
                PH_COMMENT:
                begin
                    out_next.byte_role = ROLE_COMMENT;
                end
                default:
                begin
                    out_next.byte_role = ROLE_SKIP;
                end
            endcase
        end

        // value text byte: count it and feed the number accumulator
        if (value_byte)
        begin
            value_cnt_next     = count_inc(value_cnt_reg);
            phase_next         = PH_VALUE;
            out_next.byte_role = ROLE_VALUE;
            if (idx_reg != 2'd2)
            begin
                idx_next = idx_reg + 2'd1;
            end
            if (!stopped_reg)
            begin
                if (idx_reg == 2'd1 && !hex_reg && acc_reg == '0 && q_data.is_x)
                begin
                    hex_next = 1'b1;
                end
                else if (q_data.is_dec || (hex_reg && q_data.is_hex_letter))
                begin
                    if (hex_reg)
                    begin
                        acc_next = {acc_reg[59:0], 4'b0000} + 64'(q_data.nibble);
                    end
                    else
                    begin
                        // times ten as shift-and-add
                        acc_next = {acc_reg[60:0], 3'b000} + {acc_reg[62:0], 1'b0}
                                 + 64'(q_data.nibble);
                    end
                end
                else
                begin
                    stopped_next = 1'b1;
                end
            end
        end

        close_line = q_data.brk || q_data.eof;
        name_ext   = EXT_W'(name_cnt_next);
        value_ext  = EXT_W'(value_cnt_next);

        if (close_line)
        begin
            out_next.line_done = 1'b1;
            if (flags_next.err)
            begin
                out_next.line_kind = KIND_ERROR;
            end
            else
            begin
                if (flags_next.name)
                begin
                    out_next.line_kind = KIND_ENTRY;
                end
                else if (flags_next.comment)
                begin
                    out_next.line_kind = KIND_COMMENT;
                end
                else
                begin
                    out_next.line_kind = KIND_BLANK;
                end
                out_next.has_value    = flags_next.value;
                out_next.has_comment  = flags_next.comment;
                out_next.name_length  = (name_ext > EXT_W'(16'hFFFF)) ? 16'hFFFF
                                                                       : name_ext[15:0];
                out_next.value_length = (value_ext > EXT_W'(16'hFFFF)) ? 16'hFFFF
                                                                        : value_ext[15:0];
                out_next.value_number = flags_next.value ? acc_next : 64'd0;
            end
            phase_next     = PH_LEAD;
            acc_next       = '0;
            hex_next       = 1'b0;
            stopped_next   = 1'b0;
            idx_next       = '0;
            name_cnt_next  = '0;
            value_cnt_next = '0;
            flags_next     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_LEAD;
            acc_reg       <= '0;
            hex_reg       <= 1'b0;
            stopped_reg   <= 1'b0;
            idx_reg       <= '0;
            name_cnt_reg  <= '0;
            value_cnt_reg <= '0;
            flags_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                phase_reg     <= phase_next;
                acc_reg       <= acc_next;
                hex_reg       <= hex_next;
                stopped_reg   <= stopped_next;
                idx_reg       <= idx_next;
                name_cnt_reg  <= name_cnt_next;
                value_cnt_reg <= value_cnt_next;
                flags_reg     <= flags_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            out_reg <= out_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/ini_line_tokenizer_core.sv =====
// top level of the ini line tokenizer: front classifier, queue and back parser
`default_nettype none

// Streams an ini file in one byte per item and returns one result item per
// byte: the byte's role, and on the byte that closes a line (CR, LF, or any
// byte marked end_of_file) the line kind, value and comment flags, saturated
// name and value lengths and the value read as decimal or 0x hex modulo
// 2^64. Sustained rate is one item per cycle while the output is not held;
// the limit is the back-end parse step, where the phase update and the
// 64-bit times-ten accumulate close together in the same cycle. From input
// accept to result valid an item passes the two-entry queue and then the
// output register. Input and output stall independently: the queue
// absorbs up to two items while the output is held.

module ini_line_tokenizer_core
    import ilt_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire ilt_in_t  in_data,
    output logic          out_valid,
    input  wire logic     out_ready,
    output ilt_out_t      out_data
);

    // front to queue
    logic        q_full;
    logic        q_push;
    ilt_class_t  q_wr_data;

    // queue to back
    logic        q_pop;
    logic        q_not_empty;
    ilt_class_t  q_rd_data;

    // byte classification, no state
    ilt_front u_front (
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_wr_data)
    );

    // decouples the input side from output stalls
    ilt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wr_data),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_rd_data)
    );

    // line state machine and registered result
    ilt_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_data      (q_rd_data),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

endmodule

`default_nettype wire
